// ===== src/pcdec_pkg.sv =====
package pcdec_pkg;

    // Command codes carried in the slave-side tuser
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_DECODE = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam int unsigned SYM_W  = 8;
    localparam int unsigned CODE_W = 16;
    localparam int unsigned LEN_W  = 5;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
        logic [SYM_W-1:0]  sym;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

endpackage

// ===== src/pcdec_ram.sv =====
module pcdec_ram #(
    parameter int unsigned WIDTH = 29,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/prefix_code_table_decoder_core.sv =====
// Prefix-code decoder with a loadable code table.
// Slave side: tuser carries the command (load entry, decode one bit, clear
// table); tdata carries the entry fields and the stream bit. Master side:
// tdata carries the decoded symbol, tuser the error flag.
// Load, clear and unused commands give no result.
// A decode item appends its bit to the accumulator; if the table is not empty it
// is then walked in load order through the single read port of the table RAM,
// one entry a cycle, comparing at most the fill count of entries and stopping at
// the first match, and the result is then handed to the output register.
// The block is not ready while it walks the table.
// A hit emits the symbol; MAX_CODE_LEN bits without a hit emit an error item
// with symbol zero. Either clears the accumulator.
// The output register holds a result until it is taken; a finished result
// waits in the block while the output register is still full.
// Reset empties the table and the accumulator; table contents stay undefined
// until loaded and are never compared beyond the fill count.
module prefix_code_table_decoder_core #(
    parameter int unsigned TABLE_DEPTH  = 64,
    parameter int unsigned MAX_CODE_LEN = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] entry_symbol, [23:8] entry_code, [28:24] entry_length,
    // [29] code_bit, [31:30] zero
    input  logic [31:0] i_s_axis_tdata,
    // [1:0] command
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] symbol
    output logic [7:0]  o_m_axis_tdata,
    // [0] error
    output logic [0:0]  o_m_axis_tuser
);

    import pcdec_pkg::*;

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned LW = $clog2(MAX_CODE_LEN + 1);
    localparam int unsigned XW = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;
    localparam int unsigned EW = (LW > LEN_W) ? LW : LEN_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]              r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_rd_idx, n_rd_idx;
    logic                    r_cmp_valid, n_cmp_valid;
    logic [MAX_CODE_LEN-1:0] r_acc_bits, n_acc_bits;
    logic [LW-1:0]           r_acc_len, n_acc_len;
    logic [SYM_W-1:0]        r_res_sym, n_res_sym;
    logic                    r_res_err, n_res_err;
    logic                    r_out_valid, n_out_valid;
    logic [SYM_W-1:0]        r_out_sym, n_out_sym;
    logic                    r_out_err, n_out_err;

    logic                    in_accept;
    logic [1:0]              in_cmd;
    t_entry                  in_entry;
    logic                    in_bit;
    logic                    wr_en;
    t_entry                  rd_entry;
    logic [ENTRY_W-1:0]      rd_data;
    logic [XW-1:0]           acc_mask;
    logic [XW-1:0]           code_ext;
    logic [XW-1:0]           acc_ext;
    logic                    hit;
    logic                    at_max;

    assign in_accept     = i_s_axis_tvalid && o_s_axis_tready;
    assign in_cmd        = i_s_axis_tuser;
    assign in_entry.sym  = i_s_axis_tdata[7:0];
    assign in_entry.code = i_s_axis_tdata[23:8];
    assign in_entry.len  = i_s_axis_tdata[28:24];
    assign in_bit        = i_s_axis_tdata[29];

    assign wr_en = in_accept && (in_cmd == CMD_LOAD) && (r_count < CW'(TABLE_DEPTH));

    pcdec_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (in_entry),
        .i_rd_addr (r_rd_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign rd_entry = t_entry'(rd_data);

    // Mask of the bits collected so far
    always_comb begin
        for (int k = 0; k < XW; k++) begin
            acc_mask[k] = (k < int'(r_acc_len));
        end
    end

    assign code_ext = XW'(rd_entry.code) & acc_mask;
    assign acc_ext  = XW'(r_acc_bits);
    assign hit      = r_cmp_valid && (EW'(rd_entry.len) == EW'(r_acc_len))
                      && (code_ext == acc_ext);
    assign at_max   = (r_acc_len == LW'(MAX_CODE_LEN));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_cmp_valid = 1'b0;
        n_acc_bits  = r_acc_bits;
        n_acc_len   = r_acc_len;
        n_res_sym   = r_res_sym;
        n_res_err   = r_res_err;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_sym   = r_out_sym;
        n_out_err   = r_out_err;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    priority if (in_cmd == CMD_LOAD) begin
                        if (wr_en) begin
                            n_count = r_count + CW'(1);
                        end
                    end else if (in_cmd == CMD_CLEAR) begin
                        n_count = '0;
                    end else if (in_cmd == CMD_DECODE) begin
                        n_acc_bits = {r_acc_bits[MAX_CODE_LEN-2:0], in_bit};
                        n_acc_len  = r_acc_len + LW'(1);
                        n_rd_idx   = '0;
                        if (r_count != '0) begin
                            n_state = S_WALK;
                        end else if (n_acc_len == LW'(MAX_CODE_LEN)) begin
                            // Empty table: nothing can match
                            n_res_sym  = '0;
                            n_res_err  = 1'b1;
                            n_acc_bits = '0;
                            n_acc_len  = '0;
                            n_state    = S_EMIT;
                        end
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_WALK: begin
                if (r_rd_idx < r_count) begin
                    n_rd_idx    = r_rd_idx + CW'(1);
                    n_cmp_valid = 1'b1;
                end
                if (hit) begin
                    n_res_sym  = rd_entry.sym;
                    n_res_err  = 1'b0;
                    n_acc_bits = '0;
                    n_acc_len  = '0;
                    n_state    = S_EMIT;
                end else if (r_rd_idx == r_count) begin
                    // Last entry compared without a hit
                    if (at_max) begin
                        n_res_sym  = '0;
                        n_res_err  = 1'b1;
                        n_acc_bits = '0;
                        n_acc_len  = '0;
                        n_state    = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_sym   = r_res_sym;
                    n_out_err   = r_res_err;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_cmp_valid <= 1'b0;
            r_acc_bits  <= '0;
            r_acc_len   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_cmp_valid <= n_cmp_valid;
            r_acc_bits  <= n_acc_bits;
            r_acc_len   <= n_acc_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_sym <= n_res_sym;
        r_res_err <= n_res_err;
        r_out_sym <= n_out_sym;
        r_out_err <= n_out_err;
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_sym;
    assign o_m_axis_tuser  = r_out_err;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import pcdec_pkg::*;

    localparam int TABLE_DEPTH  = 64;
    localparam int MAX_CODE_LEN = 16;
    // Command value the block does not define
    localparam logic [1:0] CMD_SPARE = 2'd3;

    typedef struct packed {
        bit          drain;
        logic [1:0]  cmd;
        logic [7:0]  sym;
        logic [15:0] code;
        logic [4:0]  len;
        logic        cbit;
    } t_item;

    typedef struct packed {
        logic [7:0] sym;
        logic       err;
    } t_result;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [7:0]  o_m_axis_tdata;
    logic [0:0]  o_m_axis_tuser;

    prefix_code_table_decoder_core #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_CODE_LEN(MAX_CODE_LEN)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    always #1 clk = ~clk;

    t_item   pending_items[$];
    t_result expected_results[$];
    int      total_items = 0;
    int      sent_items = 0;
    int      results_seen = 0;
    int      mismatches = 0;

    // Shadow of the code table as built by the stimulus
    logic [15:0] gen_code[TABLE_DEPTH];
    logic [4:0]  gen_len[TABLE_DEPTH];
    int          gen_fill = 0;

    // Decoder state mirrored at the input handshake
    logic [7:0]  tab_sym[TABLE_DEPTH];
    logic [15:0] tab_code[TABLE_DEPTH];
    logic [4:0]  tab_len[TABLE_DEPTH];
    int          tab_fill = 0;
    logic [15:0] acc_bits = '0;
    int          acc_len = 0;

    function automatic logic [15:0] low_bits(input int n);
        logic [31:0] m;
        m = (32'd1 << n) - 32'd1;
        return m[15:0];
    endfunction

    task automatic decode_step(input t_item it);
        t_result res;
        bit      hit;
        hit = 1'b0;
        res = '0;
        case (it.cmd)
            CMD_LOAD: begin
                if (tab_fill < TABLE_DEPTH) begin
                    tab_sym[tab_fill]  = it.sym;
                    tab_code[tab_fill] = it.code;
                    tab_len[tab_fill]  = it.len;
                    tab_fill++;
                end
            end
            CMD_CLEAR: tab_fill = 0;
            CMD_DECODE: begin
                acc_len++;
                acc_bits = ((acc_bits << 1) | 16'(it.cbit)) & low_bits(acc_len);
                for (int i = 0; i < tab_fill && !hit; i++) begin
                    if (tab_len[i] != 0 && tab_len[i] <= MAX_CODE_LEN && tab_len[i] == acc_len &&
                        (tab_code[i] & low_bits(int'(tab_len[i]))) == acc_bits) begin
                        hit = 1'b1;
                        res.sym = tab_sym[i];
                    end
                end
                if (hit || acc_len >= MAX_CODE_LEN) begin
                    res.err = !hit;
                    expected_results = {expected_results, res};
                    acc_bits = '0;
                    acc_len = 0;
                end
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input t_result want, input t_result got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected symbol %02h error %0d, got symbol %02h error %0d",
                     $time, what, want.sym, want.err, got.sym, got.err);
    endtask

    // Stimulus construction
    task automatic push_item(input logic [1:0] cmd, input logic [7:0] sym,
                             input logic [15:0] code, input logic [4:0] len, input logic cbit);
        t_item it;
        it.drain = 1'b0;
        it.cmd = cmd;
        it.sym = sym;
        it.code = code;
        it.len = len;
        it.cbit = cbit;
        pending_items = {pending_items, it};
        total_items++;
        if (cmd == CMD_LOAD && gen_fill < TABLE_DEPTH) begin
            gen_code[gen_fill] = code;
            gen_len[gen_fill] = len;
            gen_fill++;
        end else if (cmd == CMD_CLEAR) begin
            gen_fill = 0;
        end
    endtask

    task automatic push_decode(input logic b);
        push_item(CMD_DECODE, 8'($urandom), 16'($urandom), 5'($urandom), b);
    endtask

    task automatic push_clear();
        push_item(CMD_CLEAR, 8'($urandom), 16'($urandom), 5'($urandom), 1'($urandom));
    endtask

    task automatic push_rand_load(input bit long_codes);
        logic [4:0] len;
        if ($urandom_range(0, 19) == 0)
            len = 5'($urandom_range(0, 31));
        else if (long_codes || $urandom_range(0, 9) == 0)
            len = 5'($urandom_range(9, MAX_CODE_LEN));
        else
            len = 5'($urandom_range(1, 8));
        push_item(CMD_LOAD, 8'($urandom), 16'($urandom), len, 1'($urandom));
    endtask

    // Stream the bits of a table entry, first bit first, at most cut of them; cut random bits if it cannot match
    task automatic push_code(input int idx, input int cut);
        int n;
        n = 0;
        if (gen_fill == 0 || gen_len[idx] == 0 || gen_len[idx] > MAX_CODE_LEN) begin
            repeat (cut) push_decode(1'($urandom));
        end else begin
            for (int b = gen_len[idx] - 1; b >= 0 && n < cut; b--) begin
                push_decode(gen_code[idx][b]);
                n++;
            end
        end
    endtask

    task automatic push_pause();
        t_item it;
        it = '0;
        it.drain = 1'b1;
        pending_items = {pending_items, it};
    endtask

    // Driver
    t_item cur_item;
    t_item dropped;
    bit    offering = 1'b0;
    bit    send_calm = 1'b0;
    int    send_gap = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
            send_gap = 0;
        end else begin
            if (offering && o_s_axis_tready) begin
                decode_step(cur_item);
                sent_items++;
                offering = 1'b0;
                send_gap = send_calm ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 39) == 0)
                    send_calm = !send_calm;
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_items.size() > 0) begin
                    if (pending_items[0].drain) begin
                        // hold until the block has delivered everything
                        if (expected_results.size() == 0)
                            dropped = pending_items.pop_front();
                    end else begin
                        cur_item = pending_items.pop_front();
                        offering = 1'b1;
                        s_tdata <= {2'b00, cur_item.cbit, cur_item.len, cur_item.code,
                                    cur_item.sym};
                        s_tuser <= cur_item.cmd;
                    end
                end
            end
            s_tvalid <= offering;
        end
    end

    // Monitor
    t_result got;
    t_result want;
    bit      recv_calm = 1'b0;
    int      recv_stall = 0;
    int      hold_left = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            recv_stall = 0;
            hold_left = 0;
        end else begin
            if (o_m_axis_tvalid && m_tready) begin
                results_seen++;
                got.sym = o_m_axis_tdata;
                got.err = o_m_axis_tuser[0];
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", '0, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.sym !== want.sym || got.err !== want.err)
                        report_mismatch("wrong result", want, got);
                end
                recv_stall = recv_calm ? 0 : $urandom_range(0, 5);
                if ($urandom_range(0, 39) == 0)
                    recv_calm = !recv_calm;
                // long hold-off so the block backs up and stalls its input
                if (results_seen == 40 || results_seen == 120)
                    hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run
    int pick;
    int act;
    int full_runs;

    initial begin
        full_runs = 0;

        // Unused command with every field bit set
        push_item(CMD_SPARE, 8'hFF, 16'hFFFF, 5'h1F, 1'b1);
        // Empty table: error after the longest code
        repeat (MAX_CODE_LEN) push_decode(1'b0);
        // Zero and over-long lengths never match; high code bits are ignored
        push_item(CMD_LOAD, 8'h11, 16'h0000, 5'd0, 1'b0);
        push_item(CMD_LOAD, 8'h22, 16'h0000, 5'd31, 1'b1);
        push_item(CMD_LOAD, 8'hFF, 16'hFFFE, 5'd1, 1'b1);
        push_item(CMD_LOAD, 8'h00, 16'h0001, 5'd1, 1'b0);
        push_decode(1'b0);
        push_decode(1'b1);
        // Clear empties the table; the next bit only adds to the accumulator
        push_clear();
        push_decode(1'b1);
        push_pause();

        while (total_items < 430) begin
            pick = $urandom_range(0, 15);
            if (pick == 0 && full_runs < 2) begin
                // Fill past the table depth, then reach entries at the far end
                full_runs++;
                push_clear();
                repeat (TABLE_DEPTH + 3) push_rand_load(1'b1);
                repeat (4) push_code($urandom_range(TABLE_DEPTH - 6, TABLE_DEPTH - 1),
                                     MAX_CODE_LEN);
            end else if (pick == 1) begin
                push_clear();
                repeat ($urandom_range(16, 24)) push_decode(1'($urandom));
            end else begin
                if (pick < 8 || gen_fill == 0) begin
                    push_clear();
                    repeat ($urandom_range(1, 10)) push_rand_load(1'b0);
                end
                repeat ($urandom_range(3, 8)) begin
                    act = $urandom_range(0, 9);
                    if (act < 7) begin
                        push_code($urandom_range(0, gen_fill - 1), MAX_CODE_LEN);
                    end else if (act == 7) begin
                        // truncated code leaves the stream misaligned
                        push_code($urandom_range(0, gen_fill - 1), $urandom_range(1, 3));
                    end else if (act == 8) begin
                        case ($urandom_range(0, 2))
                            0: push_decode(1'($urandom));
                            1: push_item(CMD_SPARE, 8'($urandom), 16'($urandom),
                                         5'($urandom), 1'($urandom));
                            default: push_item(CMD_LOAD, 8'($urandom), 16'($urandom),
                                               5'($urandom), 1'($urandom));
                        endcase
                    end else begin
                        push_rand_load(1'b0);
                    end
                end
            end
            if ($urandom_range(0, 11) == 0)
                push_pause();
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_items < total_items) @(posedge clk);
        while (expected_results.size() > 0) @(posedge clk);
        repeat (TABLE_DEPTH + 16) @(posedge clk);

        if (expected_results.size() > 0) begin
            mismatches++;
            $display("%0d results never arrived", expected_results.size());
        end
        if (mismatches == 0)
            $display("prefix_code_table_decoder_core: match");
        else
            $display("prefix_code_table_decoder_core: mismatch");
        $finish;
    end

    initial begin
        #400000;
        $display("prefix_code_table_decoder_core: mismatch");
        $finish;
    end

endmodule
